@@ sv/efps_pkg.sv @@
// Shared types, constants and lookup functions of the ECU frame parser and scaler.
package efps_pkg;

  localparam int NUM_CH         = 10;
  localparam int CH_W           = 4;
  localparam int FACTOR_BITS    = 24;
  localparam int FACTOR_W       = FACTOR_BITS + 1;
  localparam int HDR_LEN        = 5;
  localparam int FIRST_DATA_POS = 6;
  localparam int LAST_DATA_POS  = FIRST_DATA_POS + 2 * NUM_CH - 1;
  localparam int POS_W          = 5;
  localparam int RAW_W          = 16;
  localparam int SCALED_W       = 33;
  localparam int PROD_W         = RAW_W + FACTOR_W;
  localparam int QUEUE_DEPTH    = 4;
  localparam int OFFSET_INT     = 40;

  localparam logic [CH_W-1:0] CH_RPM   = 4'd0;
  localparam logic [CH_W-1:0] CH_MAP   = 4'd1;
  localparam logic [CH_W-1:0] CH_TPS   = 4'd2;
  localparam logic [CH_W-1:0] CH_ECT   = 4'd3;
  localparam logic [CH_W-1:0] CH_IAT   = 4'd4;
  localparam logic [CH_W-1:0] CH_O2S   = 4'd5;
  localparam logic [CH_W-1:0] CH_SPARK = 4'd6;
  localparam logic [CH_W-1:0] CH_FPW1  = 4'd7;
  localparam logic [CH_W-1:0] CH_FPW2  = 4'd8;
  localparam logic [CH_W-1:0] CH_BATT  = 4'd9;

  // One completed channel, queued between parser and scaler
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [RAW_W-1:0] raw;
  } chan_req_t;

  // Queue status seen by the parser and the scaler
  typedef struct packed {
    logic full;
    logic nempty;
  } q_stat_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h80;
      3'd1:    b = 8'h8F;
      3'd2:    b = 8'hEA;
      3'd3:    b = 8'h16;
      3'd4:    b = 8'h50;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Channel gains as unsigned Q.24, round(factor * 2^24)
  function automatic logic [FACTOR_W-1:0] factor_q24(input logic [CH_W-1:0] ch);
    logic [FACTOR_W-1:0] f;
    unique case (ch)
      CH_RPM:   f = 25'd4194304;
      CH_MAP:   f = 25'd65431;
      CH_TPS:   f = 25'd25166;
      CH_ECT:   f = 25'd16777216;
      CH_IAT:   f = 25'd16777216;
      CH_O2S:   f = 25'd80531;
      CH_SPARK: f = 25'd8388608;
      CH_FPW1:  f = 25'd16777;
      CH_FPW2:  f = 25'd16777;
      CH_BATT:  f = 25'd104858;
      default:  f = '0;
    endcase
    return f;
  endfunction

  // Temperatures carry a -40 offset
  function automatic logic has_offset(input logic [CH_W-1:0] ch);
    return (ch == CH_ECT) || (ch == CH_IAT);
  endfunction

endpackage

@@ sv/efps_if.sv @@
// Valid/ready channel interfaces for received bytes and scaled channel results.
interface efps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efps_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel;
  logic [15:0]        raw_value;
  logic signed [32:0] scaled_value;
  logic               last_channel;

  modport source (output valid, output channel, output raw_value, output scaled_value,
                  output last_channel, input ready);
  modport sink   (input valid, input channel, input raw_value, input scaled_value,
                  input last_channel, output ready);
endinterface

@@ sv/efps_front.sv @@
// Frame tracker: header check, byte position and channel assembly.
module efps_front #(
  parameter int FRAME_BYTES = 27
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  output logic                 in_ready,
  input  efps_pkg::q_stat_t    q_stat,
  output logic                 push,
  output efps_pkg::chan_req_t  push_req
);

  localparam int PW = efps_pkg::POS_W;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    high_r, high_nxt;
  logic [PW-1:0] rel;
  logic          acc;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;
  assign rel      = pos_r - PW'(efps_pkg::FIRST_DATA_POS);

  assign push_req.ch  = rel[efps_pkg::CH_W:1];
  assign push_req.raw = {high_r, in_byte};

  always_comb begin
    pos_nxt  = pos_r;
    high_nxt = high_r;
    push     = 1'b0;
    if (acc) begin
      if ((pos_r < PW'(efps_pkg::HDR_LEN)) &&
          (in_byte != efps_pkg::hdr_byte(pos_r[2:0]))) begin
        pos_nxt = '0;
      end else begin
        if ((pos_r >= PW'(efps_pkg::FIRST_DATA_POS)) &&
            (pos_r <= PW'(efps_pkg::LAST_DATA_POS))) begin
          if (!rel[0]) begin
            high_nxt = in_byte;
          end else begin
            push = 1'b1;
          end
        end
        pos_nxt = (pos_r == PW'(FRAME_BYTES - 1)) ? '0 : pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      high_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      high_r <= high_nxt;
    end
  end

endmodule

@@ sv/efps_fifo.sv @@
// Short request queue between frame tracker and scaler.
module efps_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  efps_pkg::chan_req_t  push_req,
  input  logic                 pop,
  output efps_pkg::chan_req_t  pop_req,
  output efps_pkg::q_stat_t    q_stat
);

  localparam int DEPTH = efps_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  efps_pkg::chan_req_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign q_stat.full   = (cnt_r == (AW+1)'(DEPTH));
  assign q_stat.nempty = (cnt_r != '0);
  assign pop_req       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

@@ sv/efps_back.sv @@
// Scaler: gain multiply, truncation and offset, then the output register.
module efps_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  efps_pkg::q_stat_t    q_stat,
  input  efps_pkg::chan_req_t  pop_req,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3:0]           out_channel,
  output logic [15:0]          out_raw_value,
  output logic signed [32:0]   out_scaled_value,
  output logic                 out_last_channel
);

  localparam int SHIFT = efps_pkg::FACTOR_BITS - FRAC_BITS;
  localparam int SW    = efps_pkg::SCALED_W;
  localparam int PRW   = efps_pkg::PROD_W;
  localparam logic [SW-1:0] OFFSET_Q = SW'(efps_pkg::OFFSET_INT) << FRAC_BITS;

  logic                        s1_v_r, s1_v_nxt;
  logic [efps_pkg::CH_W-1:0]   s1_ch_r;
  logic [efps_pkg::RAW_W-1:0]  s1_raw_r;
  logic [PRW-1:0]              s1_prod_r;
  logic                        out_v_r, out_v_nxt;
  logic [3:0]                  out_ch_r;
  logic [15:0]                 out_raw_r;
  logic [SW-1:0]               out_sc_r;
  logic                        out_last_r;

  logic           adv2, take1;
  logic [PRW-1:0] prod_c, shifted_c;
  logic [SW-1:0]  scaled_c;

  assign adv2  = !out_v_r || out_ready;
  assign take1 = !s1_v_r || adv2;
  assign pop   = q_stat.nempty && take1;

  assign prod_c    = PRW'(pop_req.raw) * PRW'(efps_pkg::factor_q24(pop_req.ch));
  assign shifted_c = s1_prod_r >> SHIFT;
  assign scaled_c  = shifted_c[SW-1:0] - (efps_pkg::has_offset(s1_ch_r) ? OFFSET_Q : '0);

  always_comb begin
    s1_v_nxt  = take1 ? q_stat.nempty : s1_v_r;
    out_v_nxt = adv2 ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ch_r   <= pop_req.ch;
      s1_raw_r  <= pop_req.raw;
      s1_prod_r <= prod_c;
    end
    if (adv2 && s1_v_r) begin
      out_ch_r   <= s1_ch_r;
      out_raw_r  <= s1_raw_r;
      out_sc_r   <= scaled_c;
      out_last_r <= (s1_ch_r == efps_pkg::CH_BATT);
    end
  end

  assign out_valid        = out_v_r;
  assign out_channel      = out_ch_r;
  assign out_raw_value    = out_raw_r;
  assign out_scaled_value = signed'(out_sc_r);
  assign out_last_channel = out_last_r;

endmodule

@@ sv/ecu_frame_parser_scaler.sv @@
// Top level of the ECU frame parser and channel scaler.
//
// Usage: in_ch carries one received serial byte per request. The block
// hunts for the five-byte header, then collects ten big-endian 16-bit
// channels. out_ch carries one request per completed channel: channel
// number, raw value, raw*gain+offset as signed fixed point with FRAC_BITS
// fractional bits, and a flag on the tenth channel of the frame.
// Throughput: one byte per cycle while the queue is not full; at most one
// result per two bytes.
// Path: a channel is written to the queue when its low byte is taken, then
// passes the gain multiply stage, offset and the output register to out_ch.
// Reset (rst_n low, synchronous): position back to header hunting, held
// high byte cleared, queue and scaler pipeline emptied.
// Receiver stall: the output register holds its request, the scaler
// pipeline stops, and the 4-entry queue absorbs completed channels; only
// when it is full does in_ch.ready drop.
module ecu_frame_parser_scaler #(
  parameter int FRAME_BYTES = 27,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  efps_in_if.sink            in_ch,
  efps_out_if.source         out_ch
);

  efps_pkg::q_stat_t   q_stat;
  efps_pkg::chan_req_t push_req, pop_req;
  logic                push, pop;

  // Front: header check, byte position, channel assembly
  efps_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.rx_byte),
    .in_ready (in_ch.ready),
    .q_stat   (q_stat),
    .push     (push),
    .push_req (push_req)
  );

  // Decouples the byte stream from receiver back-pressure
  efps_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .pop_req  (pop_req),
    .q_stat   (q_stat)
  );

  // Back: gain multiply stage, then offset and output register
  efps_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .pop_req          (pop_req),
    .pop              (pop),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_channel      (out_ch.channel),
    .out_raw_value    (out_ch.raw_value),
    .out_scaled_value (out_ch.scaled_value),
    .out_last_channel (out_ch.last_channel)
  );

endmodule

@@ sv/efps_checker.sv @@
// Port-level checks on the result stream, bound to the top level.
module efps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  channel,
  input logic [15:0] raw_value,
  input logic [32:0] scaled_value,
  input logic        last_channel
);

  logic       seen_r;
  logic [3:0] prev_r;
  logic [3:0] exp_ch;

  assign exp_ch = (prev_r == efps_pkg::CH_BATT) ? efps_pkg::CH_RPM : prev_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      prev_r <= '0;
    end else if (out_valid && out_ready) begin
      seen_r <= 1'b1;
      prev_r <= channel;
    end
  end

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({channel, raw_value, scaled_value, last_channel}))
    else $error("result changed while stalled");

  // Channels of a frame arrive in order, wrapping after battery
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && seen_r |-> channel == exp_ch)
    else $error("channel out of sequence");

  // Last flag only on the battery channel
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> last_channel == (channel == efps_pkg::CH_BATT))
    else $error("last_channel does not match channel");

  // Reset empties the output
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ecu_frame_parser_scaler efps_checker u_efps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .channel      (out_ch.channel),
  .raw_value    (out_ch.raw_value),
  .scaled_value (out_ch.scaled_value),
  .last_channel (out_ch.last_channel)
);
